@@ hdl/pagp_pkg.sv @@
// ----------------------------------------------------------------------------
// pagp_pkg
// Types and constants shared by the packet age gate and percentile unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pagp_pkg;

  typedef enum logic [1:0] {
    K_LOWCONF = 2'd0,
    K_NOTS    = 2'd1,
    K_STALE   = 2'd2,
    K_INSERT  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_LOWCONF = 2'd0,
    ST_STALE   = 2'd1,
    ST_APPLIED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    F_IDLE, F_SUB, F_ABS, F_DIV, F_FIX, F_CLASS, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_APPLY, B_CAND, B_SCAN, B_EVAL, B_DONE
  } back_state_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [23:0] age;
  } entry_t;

  localparam logic [1:0] REG_MIN_CONF = 2'd0;
  localparam logic [1:0] REG_MAX_AGE  = 2'd1;
  localparam logic [1:0] REG_WIN_SIZE = 2'd2;

  localparam logic signed [23:0] AGE_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] AGE_MIN = 24'sh800000;
  // |ns| from here on saturates the microsecond age
  localparam logic [63:0] SAT_NS   = 64'd8388608000;
  // ceil(2^37 / 125): exact quotient for any 30-bit dividend
  localparam logic [30:0] RECIP_125 = 31'd1099511628;
  localparam int unsigned WIN_MIN  = 10;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

endpackage

`default_nettype wire

@@ hdl/pagp_if.sv @@
// ----------------------------------------------------------------------------
// pagp_in_if / pagp_out_if
// Valid/ready item channels for packets in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pagp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] confidence;
  logic [62:0] capture_time_ns;
  logic [62:0] now_time_ns;
  modport source(output valid, confidence, capture_time_ns, now_time_ns, input ready);
  modport sink(input valid, confidence, capture_time_ns, now_time_ns, output ready);
endinterface

interface pagp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [23:0] last_age_us;
  logic signed [23:0] age_p50_us;
  logic signed [23:0] age_p95_us;
  logic [31:0]        applied_total;
  logic [31:0]        stale_drops;
  logic [31:0]        confidence_drops;
  modport source(output valid, status, last_age_us, age_p50_us, age_p95_us,
                 applied_total, stale_drops, confidence_drops, input ready);
  modport sink(input valid, status, last_age_us, age_p50_us, age_p95_us,
               applied_total, stale_drops, confidence_drops, output ready);
endinterface

`default_nettype wire

@@ hdl/pagp_front.sv @@
// ----------------------------------------------------------------------------
// pagp_front
// Accepts packets, gates on confidence, derives the saturated age in us
// (ns/8 times a reciprocal of 125) and classifies each item for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pagp_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  pagp_in_if.sink              in_item,
  input  wire logic [15:0]     min_confidence,
  input  wire logic [22:0]     max_age_us,
  output pagp_pkg::entry_t     push_entry,
  output logic                 push_valid,
  input  wire logic            push_full
);
  import pagp_pkg::*;

  front_state_t       state_r, state_nxt;
  kind_t              kind_r;
  logic [62:0]        cap_r, now_r;
  logic [63:0]        diff_r, absv;
  logic               neg_r;
  logic [29:0]        y_r;
  logic [60:0]        prod;
  logic [22:0]        q_r;
  logic signed [23:0] age_r;
  logic               low_conf, no_ts;

  assign low_conf = in_item.confidence < min_confidence;
  assign no_ts    = in_item.capture_time_ns == 63'd0;
  assign absv     = diff_r[63] ? (~diff_r + 64'd1) : diff_r;
  assign prod     = {31'd0, y_r} * {30'd0, RECIP_125};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (in_item.valid) begin
          cap_r  <= in_item.capture_time_ns;
          now_r  <= in_item.now_time_ns;
          kind_r <= low_conf ? K_LOWCONF : (no_ts ? K_NOTS : K_INSERT);
        end
      end
      F_SUB: diff_r <= {1'b0, now_r} - {1'b0, cap_r};
      F_ABS: begin
        neg_r <= diff_r[63];
        if (absv >= SAT_NS) begin
          age_r <= diff_r[63] ? AGE_MIN : AGE_MAX;
        end else begin
          y_r <= absv[32:3];
        end
      end
      // floor(ns/1000) = floor(floor(ns/8)/125)
      F_DIV: q_r <= prod[59:37];
      F_FIX: age_r <= neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
      F_CLASS: begin
        if (age_r > $signed({1'b0, max_age_us})) begin
          kind_r <= K_STALE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    in_item.ready = 1'b0;
    push_valid    = 1'b0;
    case (state_r)
      F_IDLE: begin
        in_item.ready = 1'b1;
        if (in_item.valid) begin
          state_nxt = (low_conf || no_ts) ? F_PUSH : F_SUB;
        end
      end
      F_SUB:   state_nxt = F_ABS;
      F_ABS:   state_nxt = (absv >= SAT_NS) ? F_CLASS : F_DIV;
      F_DIV:   state_nxt = F_FIX;
      F_FIX:   state_nxt = F_CLASS;
      F_CLASS: state_nxt = F_PUSH;
      F_PUSH: begin
        push_valid = !push_full;
        if (!push_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign push_entry.kind = kind_r;
  assign push_entry.age  = age_r;

endmodule

`default_nettype wire

@@ hdl/pagp_queue.sv @@
// ----------------------------------------------------------------------------
// pagp_queue
// Two-entry queue of classified items between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pagp_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pagp_pkg::entry_t push_entry,
  input  wire logic             push_valid,
  output logic                  full,
  output pagp_pkg::entry_t      pop_entry,
  output logic                  pop_avail,
  input  wire logic             pop
);
  import pagp_pkg::*;

  entry_t     slot_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r == 2'd2;
  assign pop_avail = cnt_r != 2'd0;
  assign pop_entry = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slot_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_valid) wr_r <= ~wr_r;
      if (pop)        rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push_valid} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

@@ hdl/pagp_back.sv @@
// ----------------------------------------------------------------------------
// pagp_back
// Age ring, counters and percentile ranking; drives the result register.
// Each window entry is ranked against the whole window over the memory ports.
// ----------------------------------------------------------------------------
`default_nettype none

module pagp_back #(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pagp_pkg::entry_t pop_entry,
  input  wire logic             pop_avail,
  output logic                  pop,
  input  wire logic [6:0]       window_size,
  pagp_out_if.source            out_item
);
  import pagp_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FW = $clog2(WINDOW_MAX + 1);
  localparam int LW = (FW > 7) ? FW : 7;

  back_state_t        state_r, state_nxt;
  entry_t             cur_r;
  logic signed [23:0] mem [WINDOW_MAX];
  logic signed [23:0] rda_r, rdb_r;
  logic [AW-1:0]      wp_r, wslot_r, ci_r, cj_r;
  logic [FW-1:0]      fill_r, j_r, oi_r, lt_r, le_r, k95_r;
  logic               vb_r;
  logic signed [23:0] last_age_r, p50_r, p95_r;
  logic [31:0]        applied_r, stale_r, lowc_r;
  logic               out_valid_r;
  logic [1:0]         status_r;
  logic signed [23:0] o_last_r, o_p50_r, o_p95_r;
  logic [31:0]        o_app_r, o_stale_r, o_lowc_r;
  logic               mem_we;
  logic [LW-1:0]      ws_ext, lim;
  logic [FW-1:0]      lim_f, fill_inc, m, k50, quarter, c20;
  logic [FW:0]        m19;
  logic [FW+14:0]     prod;

  function automatic logic [AW-1:0] dec_ptr(input logic [AW-1:0] p);
    return (p == '0) ? AW'(WINDOW_MAX - 1) : p - AW'(1);
  endfunction

  assign ws_ext   = LW'(window_size);
  assign lim      = (ws_ext < LW'(WIN_MIN)) ? LW'(WIN_MIN) :
                    ((ws_ext > LW'(WINDOW_MAX)) ? LW'(WINDOW_MAX) : ws_ext);
  assign lim_f    = FW'(lim);
  assign fill_inc = (fill_r + FW'(1) > lim_f) ? lim_f : fill_r + FW'(1);
  assign m        = fill_r - FW'(1);
  assign k50      = m >> 1;
  // p95 index = m - ceil(m/20); /5 by reciprocal
  assign m19      = {1'b0, m} + (FW+1)'(19);
  assign quarter  = FW'(m19 >> 2);
  assign prod     = (FW+15)'(quarter) * (FW+15)'(52429);
  assign c20      = FW'(prod >> 18);

  assign mem_we   = (state_r == B_APPLY) && (cur_r.kind == K_INSERT);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= cur_r.age;
    end
    rda_r <= mem[ci_r];
    rdb_r <= mem[cj_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      fill_r      <= '0;
      last_age_r  <= '0;
      p50_r       <= '0;
      p95_r       <= '0;
      applied_r   <= '0;
      stale_r     <= '0;
      lowc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_item.ready) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (pop_avail && !out_valid_r) cur_r <= pop_entry;
        end
        B_APPLY: begin
          case (cur_r.kind)
            K_LOWCONF: lowc_r <= sat_inc(lowc_r);
            K_NOTS:    applied_r <= sat_inc(applied_r);
            K_STALE: begin
              last_age_r <= cur_r.age;
              stale_r    <= sat_inc(stale_r);
            end
            K_INSERT: begin
              last_age_r <= cur_r.age;
              applied_r  <= sat_inc(applied_r);
              wslot_r    <= wp_r;
              ci_r       <= wp_r;
              wp_r       <= (wp_r == AW'(WINDOW_MAX - 1)) ? '0 : wp_r + AW'(1);
              fill_r     <= fill_inc;
              oi_r       <= '0;
            end
            default: ;
          endcase
        end
        B_CAND: begin
          k95_r <= m - c20;
          cj_r  <= wslot_r;
          j_r   <= '0;
          lt_r  <= '0;
          le_r  <= '0;
          vb_r  <= 1'b0;
        end
        B_SCAN: begin
          vb_r <= j_r < fill_r;
          if (j_r < fill_r) begin
            cj_r <= dec_ptr(cj_r);
            j_r  <= j_r + FW'(1);
          end
          if (vb_r) begin
            if (rdb_r < rda_r)  lt_r <= lt_r + FW'(1);
            if (rdb_r <= rda_r) le_r <= le_r + FW'(1);
          end
        end
        B_EVAL: begin
          if (lt_r <= k50 && k50 < le_r)     p50_r <= rda_r;
          if (lt_r <= k95_r && k95_r < le_r) p95_r <= rda_r;
          oi_r <= oi_r + FW'(1);
          ci_r <= dec_ptr(ci_r);
        end
        B_DONE: begin
          out_valid_r <= 1'b1;
          status_r    <= (cur_r.kind == K_LOWCONF) ? ST_LOWCONF :
                         ((cur_r.kind == K_STALE) ? ST_STALE : ST_APPLIED);
          o_last_r    <= last_age_r;
          o_p50_r     <= p50_r;
          o_p95_r     <= p95_r;
          o_app_r     <= applied_r;
          o_stale_r   <= stale_r;
          o_lowc_r    <= lowc_r;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (pop_avail && !out_valid_r) begin
          pop       = 1'b1;
          state_nxt = B_APPLY;
        end
      end
      B_APPLY: state_nxt = (cur_r.kind == K_INSERT) ? B_CAND : B_DONE;
      B_CAND:  state_nxt = B_SCAN;
      B_SCAN:  state_nxt = (j_r == fill_r && vb_r) ? B_EVAL : B_SCAN;
      B_EVAL:  state_nxt = (oi_r == m) ? B_DONE : B_CAND;
      B_DONE:  state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  assign out_item.valid            = out_valid_r;
  assign out_item.status           = status_r;
  assign out_item.last_age_us      = o_last_r;
  assign out_item.age_p50_us       = o_p50_r;
  assign out_item.age_p95_us       = o_p95_r;
  assign out_item.applied_total    = o_app_r;
  assign out_item.stale_drops      = o_stale_r;
  assign out_item.confidence_drops = o_lowc_r;

endmodule

`default_nettype wire

@@ hdl/packet_age_gate_percentile_unit.sv @@
// ----------------------------------------------------------------------------
// packet_age_gate_percentile_unit
// Confidence and age gate for timestamped packets with windowed p50/p95 age.
// ----------------------------------------------------------------------------
// One packet is in the front end at a time. A dropped or untimestamped
// packet goes straight to the queue; any other timestamped one passes the
// subtraction and absolute value, then, unless its age saturates, the
// reciprocal multiplication that turns nanoseconds into microseconds and
// the sign fix-up, and last the stale compare. For an applied age, the back
// end ranks each window entry against the window through the ring memory's
// two read ports; other items are not ranked. A two-item queue lets both
// ends run apart, and the result register holds one item until taken.
`default_nettype none

module packet_age_gate_percentile_unit #(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pagp_in_if.sink          in_item,
  pagp_out_if.source       out_item,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import pagp_pkg::*;

  logic [15:0] min_conf_r;
  logic [22:0] max_age_r;
  logic [6:0]  win_size_r;
  entry_t      push_entry, pop_entry;
  logic        push_valid, push_full, pop_avail, pop;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_conf_r <= 16'd32768;
      max_age_r  <= 23'd100000;
      win_size_r <= 7'd32;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_MIN_CONF: min_conf_r <= cfg_pwdata[15:0];
        REG_MAX_AGE:  max_age_r  <= cfg_pwdata[22:0];
        REG_WIN_SIZE: win_size_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_MIN_CONF: cfg_prdata = {16'd0, min_conf_r};
      REG_MAX_AGE:  cfg_prdata = {9'd0, max_age_r};
      REG_WIN_SIZE: cfg_prdata = {25'd0, win_size_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  pagp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_item        (in_item),
    .min_confidence (min_conf_r),
    .max_age_us     (max_age_r),
    .push_entry     (push_entry),
    .push_valid     (push_valid),
    .push_full      (push_full)
  );

  pagp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .full       (push_full),
    .pop_entry  (pop_entry),
    .pop_avail  (pop_avail),
    .pop        (pop)
  );

  pagp_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_entry   (pop_entry),
    .pop_avail   (pop_avail),
    .pop         (pop),
    .window_size (win_size_r),
    .out_item    (out_item)
  );

endmodule

`default_nettype wire
